[src/cep_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// cep_pkg: shared types, constants and coefficient tables for the cluster error unit.
// Used by cep_div, cep_poly and cluster_error_parameterization_unit. No dependencies.
package cep_pkg;

    // Input mode codes
    typedef enum logic {
        MODE_POLY = 1'b0,
        MODE_RMS  = 1'b1
    } t_mode;

    // Row classes; the fourth code is never produced
    typedef enum logic [1:0] {
        ROW_LOW  = 2'd0,
        ROW_HIGH = 2'd1,
        ROW_MID  = 2'd2
    } t_row_type;

    // Configuration register indexes
    typedef enum logic {
        CFG_CORR_Y = 1'b0,
        CFG_CORR_Z = 1'b1
    } t_cfg_idx;

    localparam int ZD_W   = 18;   // drift distance, Q.10
    localparam int DIV_W  = 26;   // quotient bits = divider stages
    localparam int REM_W  = 30;   // divider remainder
    localparam int DEN_W  = 31;   // divider denominator, up to 2^30
    localparam int X_W    = 41;   // |sum| >> 23
    localparam int GAIN_W = 24;
    localparam int POLY_LAT = 8;  // register stages in cep_poly

    localparam logic [19:0]    DRIFT_END_Q10 = 20'd255718;
    localparam logic [30:0]    S2_MAX_Q30    = 31'd969051996;
    localparam logic [30:0]    ONE_Q30       = 31'd1073741824;
    localparam logic [63:0]    ERR_FLOOR_Q47 = 64'd1407374883553;
    localparam logic [23:0]    GAIN_ONE      = 24'd65536;

    typedef struct packed {
        t_mode             mode;
        t_row_type         rt;
        logic [ZD_W-1:0]   zd;
    } t_side;

    typedef struct packed {
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [31:0] c3;
        logic signed [31:0] c4;
        logic signed [31:0] c5;
    } t_coefs;

    typedef logic signed [31:0] t_err_rom [0:35];
    typedef logic signed [31:0] t_rms_rom [0:23];

    // Decimal defaults: value = mant * 10^-dexp
    localparam longint ERR_MANT [0:35] = '{
        64'sd6459134747,  64'sd2515474080, 64'sd1575511135,
        64'sd1998728116, -64'sd5867697299, 64'sd9163015056,
        64'sd9715468041,  64'sd1709380558, 64'sd2170840092,
        64'sd3902757584, -64'sd1686310396, 64'sd8404983237,
        64'sd7274691598,  64'sd2638693149, 64'sd3296907991,
       -64'sd2192744297,  64'sd1773788221, 64'sd3265957275,
        64'sd1468741451,  64'sd6362320619, 64'sd1286654267,
        64'sd1194094494,  64'sd1158837788, 64'sd1321796444,
        64'sd1159700332,  64'sd1304523357, 64'sd1870155707,
        64'sd5397667380,  64'sd1647908241, 64'sd1441156346,
        64'sd6279404624,  64'sd1785200948, 64'sd2835378610,
        64'sd1168677422,  64'sd5026077852, 64'sd1885100210
    };
    localparam int ERR_DEXP [0:35] = '{
        13, 14, 11, 17, 12, 14,
        13, 14, 11, 17, 12, 14,
        14, 14, 11, 17, 11, 14,
        12, 15, 11, 16, 11, 13,
        12, 14, 11, 17, 11, 13,
        13, 14, 11, 17, 11, 13
    };
    localparam longint RMS_MANT [0:23] = '{
        64'sd4175168648, 64'sd1876236493, 64'sd5637887120, 64'sd5383737683,
        64'sd8294349909, 64'sd2032917109, 64'sd6815388054, 64'sd9709653258,
        64'sd8675435185, 64'sd2107333421, 64'sd1383669674, 64'sd2550894618,
        64'sd5962546170, 64'sd8628865180, 64'sd3617763892, 64'sd4797043204,
        64'sd6125717238, 64'sd7239293336, 64'sd3930576518, 64'sd9292225838,
        64'sd6584659219, 64'sd1036396061, 64'sd6075834110, 64'sd9902895093
    };
    localparam int RMS_DEXP [0:23] = '{
        11, 13, 11, 10,
        11, 13, 11, 10,
        11, 13, 10, 10,
        11, 14, 11, 10,
        11, 14, 11, 10,
        11, 13, 11, 10
    };

    // round(mant * 10^-dexp * 2^frac), long division bit by bit (elaboration only)
    function automatic logic signed [31:0] dec_to_fixed(longint mant, int dexp, int frac);
        logic [63:0] u;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        logic [31:0] qn;
        int i;
        u = (mant < 0) ? 64'(-mant) : 64'(mant);
        d = 64'd1;
        for (i = 0; i < dexp; i++) d = d * 64'd10;
        q = '0;
        r = '0;
        for (i = 63; i >= 0; i--) begin
            r = {r[62:0], u[i]};
            q = {q[62:0], 1'b0};
            if (r >= d) begin
                q[0] = 1'b1;
                r = r - d;
            end
        end
        for (i = 0; i < frac; i++) begin
            r = {r[62:0], 1'b0};
            q = {q[62:0], 1'b0};
            if (r >= d) begin
                q[0] = 1'b1;
                r = r - d;
            end
        end
        if ({r[62:0], 1'b0} >= d) q = q + 64'd1;
        qn = q[31:0];
        return (mant < 0) ? $signed(-qn) : $signed(qn);
    endfunction

    function automatic t_err_rom build_err_rom();
        t_err_rom rom;
        int i;
        for (i = 0; i < 36; i++)
            rom[i] = dec_to_fixed(ERR_MANT[i], ERR_DEXP[i], ((i % 6) == 3) ? 47 : 31);
        return rom;
    endfunction

    function automatic t_rms_rom build_rms_rom();
        t_rms_rom rom;
        int i;
        for (i = 0; i < 24; i++)
            rom[i] = dec_to_fixed(RMS_MANT[i], RMS_DEXP[i], 31);
        return rom;
    endfunction

    localparam t_err_rom ERR_ROM = build_err_rom();
    localparam t_rms_rom RMS_ROM = build_rms_rom();

    // Coefficient set for one lane; RMS mode uses the linear terms only
    function automatic t_coefs fetch_coefs(logic lane_z, t_row_type rt, t_mode md);
        t_coefs c;
        int eb;
        int rb;
        case (rt)
            ROW_LOW:  begin eb = 0;  rb = 0; end
            ROW_HIGH: begin eb = 6;  rb = 4; end
            ROW_MID:  begin eb = 12; rb = 8; end
            default:  begin eb = 0;  rb = 0; end
        endcase
        if (lane_z) begin
            eb = eb + 18;
            rb = rb + 12;
        end
        if (md == MODE_POLY) begin
            c.c0 = ERR_ROM[eb];
            c.c1 = ERR_ROM[eb + 1];
            c.c2 = ERR_ROM[eb + 2];
            c.c3 = ERR_ROM[eb + 3];
            c.c4 = ERR_ROM[eb + 4];
            c.c5 = ERR_ROM[eb + 5];
        end else begin
            c.c0 = RMS_ROM[rb];
            c.c1 = RMS_ROM[rb + 1];
            c.c2 = RMS_ROM[rb + 2];
            c.c3 = '0;
            c.c4 = '0;
            c.c5 = '0;
        end
        return c;
    endfunction

    // One restoring divide step: {quotient bit, new remainder}
    function automatic logic [REM_W:0] div_step(logic [REM_W-1:0] rem, logic b,
                                                logic [DEN_W-1:0] den);
        logic [REM_W:0] t;
        logic [REM_W:0] diff;
        t = {rem, b};
        diff = t - den;
        if (t >= den) return {1'b1, diff[REM_W-1:0]};
        return {1'b0, t[REM_W-1:0]};
    endfunction

endpackage
`default_nettype wire

[src/cep_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// cep_div: two-lane pipelined restoring divider, one quotient bit per stage,
// shared denominator, sideband carried along. Depends on cep_pkg.
module cep_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  cep_pkg::t_side              i_side,
    input  logic [cep_pkg::DEN_W-1:0]   i_den,
    input  logic [cep_pkg::REM_W-1:0]   i_num_y_hi,
    input  logic [cep_pkg::DIV_W-1:0]   i_num_y_lo,
    input  logic [cep_pkg::REM_W-1:0]   i_num_z_hi,
    input  logic [cep_pkg::DIV_W-1:0]   i_num_z_lo,
    output logic                        o_valid,
    output cep_pkg::t_side              o_side,
    output logic [cep_pkg::DIV_W-1:0]   o_quot_y,
    output logic [cep_pkg::DIV_W-1:0]   o_quot_z
);
    import cep_pkg::*;

    // low numerator bits shift out at the top while quotient bits shift in
    logic               r_v     [DIV_W];
    t_side              r_side  [DIV_W];
    logic [DEN_W-1:0]   r_den   [DIV_W];
    logic [REM_W-1:0]   r_rem_y [DIV_W];
    logic [REM_W-1:0]   r_rem_z [DIV_W];
    logic [DIV_W-1:0]   r_lo_y  [DIV_W];
    logic [DIV_W-1:0]   r_lo_z  [DIV_W];

    for (genvar g = 0; g < DIV_W; g++) begin : g_stage
        logic               src_v;
        t_side              src_side;
        logic [DEN_W-1:0]   src_den;
        logic [REM_W-1:0]   src_rem_y;
        logic [REM_W-1:0]   src_rem_z;
        logic [DIV_W-1:0]   src_lo_y;
        logic [DIV_W-1:0]   src_lo_z;
        logic [REM_W:0]     step_y;
        logic [REM_W:0]     step_z;

        if (g == 0) begin : g_first
            assign src_v     = i_valid;
            assign src_side  = i_side;
            assign src_den   = i_den;
            assign src_rem_y = i_num_y_hi;
            assign src_rem_z = i_num_z_hi;
            assign src_lo_y  = i_num_y_lo;
            assign src_lo_z  = i_num_z_lo;
        end else begin : g_next
            assign src_v     = r_v[g-1];
            assign src_side  = r_side[g-1];
            assign src_den   = r_den[g-1];
            assign src_rem_y = r_rem_y[g-1];
            assign src_rem_z = r_rem_z[g-1];
            assign src_lo_y  = r_lo_y[g-1];
            assign src_lo_z  = r_lo_z[g-1];
        end

        assign step_y = div_step(src_rem_y, src_lo_y[DIV_W-1], src_den);
        assign step_z = div_step(src_rem_z, src_lo_z[DIV_W-1], src_den);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= src_v;
            end
            r_side[g]  <= src_side;
            r_den[g]   <= src_den;
            r_rem_y[g] <= step_y[REM_W-1:0];
            r_rem_z[g] <= step_z[REM_W-1:0];
            r_lo_y[g]  <= {src_lo_y[DIV_W-2:0], step_y[REM_W]};
            r_lo_z[g]  <= {src_lo_z[DIV_W-2:0], step_z[REM_W]};
        end
    end

    assign o_valid  = r_v[DIV_W-1];
    assign o_side   = r_side[DIV_W-1];
    assign o_quot_y = r_lo_y[DIV_W-1];
    assign o_quot_z = r_lo_z[DIV_W-1];

    // partial remainders stay below the divisor at every stage
    for (genvar g = 0; g < DIV_W; g++) begin : g_chk
        a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_v[g] |-> (r_rem_y[g] < r_den[g]) && (r_rem_z[g] < r_den[g]))
            else $error("divider remainder out of range");
    end

    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, DIV_W))
        else $error("divider result without matching entry");

endmodule
`default_nettype wire

[src/cep_poly.sv]
`timescale 1ns / 1ps
`default_nettype none
// cep_poly: one lane of the error polynomial, magnitude, floor, gain or square,
// 32-bit saturation; eight register stages. Depends on cep_pkg.
module cep_poly (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  cep_pkg::t_mode               i_mode,
    input  cep_pkg::t_coefs              i_coefs,
    input  logic [cep_pkg::ZD_W-1:0]     i_zd,
    input  logic [cep_pkg::DIV_W-1:0]    i_a,
    input  logic [cep_pkg::GAIN_W-1:0]   i_gain,
    output logic                         o_valid,
    output logic [31:0]                  o_err
);
    import cep_pkg::*;

    logic [POLY_LAT-1:0] r_vld;

    // P1: first-level products
    t_mode              r1_mode;
    logic signed [31:0] r1_c0, r1_c3, r1_c4, r1_c5;
    logic signed [50:0] r1_m1;
    logic signed [58:0] r1_m2;
    logic [35:0]        r1_zz;
    logic [51:0]        r1_aa;
    logic [43:0]        r1_za;
    // P2: linear-term sum, split products of the quadratic terms
    t_mode              r2_mode;
    logic signed [63:0] r2_s012;
    logic signed [50:0] r2_p3h, r2_p3l, r2_p4h, r2_p4l, r2_p5h, r2_p5l;
    // P3..P5: reduction
    t_mode              r3_mode, r4_mode, r5_mode, r6_mode, r7_mode;
    logic signed [63:0] r3_s012, r3_t3, r3_t4, r3_t5;
    logic signed [63:0] r4_acc1, r4_acc2;
    logic signed [63:0] r5_acc;
    // P6..P8: scaling
    logic [X_W-1:0]     r6_x;
    logic [40:0]        r7_mh;
    logic [47:0]        r7_ml;
    logic [63:0]        r7_sq;
    logic               r7_ovf;
    logic [31:0]        r_err;

    logic [35:0]        n_x4, n_x5;
    logic signed [63:0] n_t3f;
    logic [63:0]        n_mag, n_v0;
    logic [41:0]        n_sum;
    logic [31:0]        n_err;

    always_comb begin
        n_x4  = r1_aa[51:16];
        n_x5  = 36'(r1_za[43:10]);
        n_t3f = (64'(r2_p3h) <<< 18) + 64'(r2_p3l);
        n_mag = r5_acc[63] ? 64'(-r5_acc) : 64'(r5_acc);
        n_v0  = (n_mag < ERR_FLOOR_Q47) ? ERR_FLOOR_Q47 : n_mag;
        n_sum = 42'(r7_mh) + 42'(r7_ml[47:24]);
        case (r7_mode)
            MODE_POLY: n_err = (|n_sum[41:32]) ? '1 : n_sum[31:0];
            MODE_RMS:  n_err = r7_ovf ? '1 : r7_sq[63:32];
            default:   n_err = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[POLY_LAT-2:0], i_valid};
        end
        // P1
        r1_mode <= i_mode;
        r1_c0   <= i_coefs.c0;
        r1_c3   <= i_coefs.c3;
        r1_c4   <= i_coefs.c4;
        r1_c5   <= i_coefs.c5;
        r1_m1   <= $signed(i_coefs.c1) * $signed({1'b0, i_zd});
        r1_m2   <= $signed(i_coefs.c2) * $signed({1'b0, i_a});
        r1_zz   <= 36'(i_zd) * 36'(i_zd);
        r1_aa   <= 52'(i_a) * 52'(i_a);
        r1_za   <= 44'(i_zd) * 44'(i_a);
        // P2
        r2_mode <= r1_mode;
        r2_s012 <= (64'(r1_c0) <<< 16) + (64'(r1_m1) <<< 6) + 64'(r1_m2);
        r2_p3h  <= r1_c3 * $signed({1'b0, r1_zz[35:18]});
        r2_p3l  <= r1_c3 * $signed({1'b0, r1_zz[17:0]});
        r2_p4h  <= r1_c4 * $signed({1'b0, n_x4[35:18]});
        r2_p4l  <= r1_c4 * $signed({1'b0, n_x4[17:0]});
        r2_p5h  <= r1_c5 * $signed({1'b0, n_x5[35:18]});
        r2_p5l  <= r1_c5 * $signed({1'b0, n_x5[17:0]});
        // P3
        r3_mode <= r2_mode;
        r3_s012 <= r2_s012;
        r3_t3   <= n_t3f >>> 20;
        r3_t4   <= (64'(r2_p4h) <<< 18) + 64'(r2_p4l);
        r3_t5   <= (64'(r2_p5h) <<< 18) + 64'(r2_p5l);
        // P4, P5
        r4_mode <= r3_mode;
        r4_acc1 <= r3_s012 + r3_t3;
        r4_acc2 <= r3_t4 + r3_t5;
        r5_mode <= r4_mode;
        r5_acc  <= r4_acc1 + r4_acc2;
        // P6: magnitude, floor in poly mode
        r6_mode <= r5_mode;
        r6_x    <= (r5_mode == MODE_RMS) ? n_mag[63:23] : n_v0[63:23];
        // P7: gain product in two pieces, square of the RMS value
        r7_mode <= r6_mode;
        r7_mh   <= 41'(r6_x[40:24]) * 41'(i_gain);
        r7_ml   <= 48'(r6_x[23:0]) * 48'(i_gain);
        r7_sq   <= 64'(r6_x[31:0]) * 64'(r6_x[31:0]);
        r7_ovf  <= |r6_x[40:32];
        // P8
        r_err   <= n_err;
    end

    assign o_valid = r_vld[POLY_LAT-1];
    assign o_err   = r_err;

    a_poly_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, POLY_LAT))
        else $error("polynomial result without matching entry");

endmodule
`default_nettype wire

[src/cluster_error_parameterization_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// cluster_error_parameterization_unit: top level of the cluster error block.
// Depends on cep_pkg, cep_div and cep_poly.
//
// Usage:
//   Command channel: a transaction is taken at each rising edge with start high
//   and busy low. busy is high while reset is applied and for the first cycle
//   after it; from then on one cluster can enter every cycle.
//   Result channel: o_valid marks o_err_y2 / o_err_z2 for exactly one cycle;
//   there is no back-pressure, the receiver must take each result.
//   Config port: i_cfg_we / i_cfg_idx / i_cfg_data write the y or z gain;
//   write only while no transaction is in flight.
//   Throughput: one transaction per cycle, in order.
//   Depth comes from the 26-stage two-lane divider (one quotient bit per stage)
//   that forms the slope angles, plus two front stages, the coefficient fetch
//   and eight stages of polynomial and scaling arithmetic.
//   Reset (synchronous, active low) empties the pipeline and sets both gains to
//   1.0. Coefficient tables are constants.
module cluster_error_parameterization_unit #(
    parameter int ROW_TYPE_LOW_END    = 63,
    parameter int ROW_TYPE_HIGH_START = 126
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_mode,
    input  logic [7:0]            i_row,
    input  logic signed [18:0]    i_z_pos,
    input  logic signed [15:0]    i_sin_phi,
    input  logic signed [15:0]    i_dz_ds,
    input  logic                  i_cfg_we,
    input  cep_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [23:0]           i_cfg_data,
    output logic                  o_valid,
    output logic [31:0]           o_err_y2,
    output logic [31:0]           o_err_z2
);
    import cep_pkg::*;

    localparam logic [7:0] LOW_END_ROW    = 8'(ROW_TYPE_LOW_END);
    localparam logic [7:0] HIGH_START_ROW = 8'(ROW_TYPE_HIGH_START);
    localparam int         LATENCY        = 2 + DIV_W + 1 + POLY_LAT;

    logic r_busy;
    logic accept;

    // gains, Q8.16
    logic [GAIN_W-1:0] r_corr_y, r_corr_z;

    // S1: row class, drift distance, squares
    logic              r_s1_v;
    t_mode             r_s1_mode;
    t_row_type         r_s1_rt;
    logic [ZD_W-1:0]   r_s1_zd;
    logic [30:0]       r_s1_sp2;
    logic [30:0]       r_s1_dz2;
    // S2: clamp and denominator, divider operands
    logic              r_s2_v;
    t_side             r_s2_side;
    logic [DEN_W-1:0]  r_s2_den;
    logic [REM_W-1:0]  r_s2_ny_hi, r_s2_nz_hi;
    logic [DIV_W-1:0]  r_s2_ny_lo, r_s2_nz_lo;
    // P0: coefficient fetch
    logic              r_p0_v;
    t_mode             r_p0_mode;
    logic [ZD_W-1:0]   r_p0_zd;
    logic [DIV_W-1:0]  r_p0_ay, r_p0_az;
    t_coefs            r_p0_cy, r_p0_cz;

    logic [18:0]        n_abs_z;
    logic signed [19:0] n_diff;
    logic [ZD_W-1:0]    n_zd;
    t_row_type          n_rt;
    logic signed [31:0] n_sp_sq, n_dz_sq;
    logic [30:0]        n_s2c;

    logic              div_v;
    t_side             div_side;
    logic [DIV_W-1:0]  div_qy, div_qz;
    logic              lane_y_v, lane_z_v;

    // reset blocks the command channel directly
    assign busy   = r_busy || !i_rst_n;
    assign accept = start && !busy;

    always_comb begin
        n_abs_z = i_z_pos[18] ? 19'(-i_z_pos) : 19'(i_z_pos);
        n_diff  = $signed(DRIFT_END_Q10) - $signed({1'b0, n_abs_z});
        n_zd    = n_diff[19] ? ZD_W'(-n_diff) : n_diff[ZD_W-1:0];
        // low-end test first, so any parameter pair gives a class
        if (i_row < LOW_END_ROW)       n_rt = ROW_LOW;
        else if (i_row > HIGH_START_ROW) n_rt = ROW_HIGH;
        else                           n_rt = ROW_MID;
        n_sp_sq = i_sin_phi * i_sin_phi;
        n_dz_sq = i_dz_ds * i_dz_ds;
        // full-scale sine lands at 1.0 and is caught by the clamp
        n_s2c   = (r_s1_sp2 > S2_MAX_Q30) ? S2_MAX_Q30 : r_s1_sp2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_p0_v   <= 1'b0;
            r_corr_y <= GAIN_ONE;
            r_corr_z <= GAIN_ONE;
        end else begin
            r_busy <= 1'b0;
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            r_p0_v <= div_v;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CORR_Y: r_corr_y <= i_cfg_data;
                    CFG_CORR_Z: r_corr_z <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        // S1
        r_s1_mode <= t_mode'(i_mode);
        r_s1_rt   <= n_rt;
        r_s1_zd   <= n_zd;
        r_s1_sp2  <= n_sp_sq[30:0];
        r_s1_dz2  <= n_dz_sq[30:0];
        // S2: aY numerator s2 << 16, aZ numerator dz2 << 22, split hi/lo
        r_s2_side  <= '{mode: r_s1_mode, rt: r_s1_rt, zd: r_s1_zd};
        r_s2_den   <= ONE_Q30 - n_s2c;
        r_s2_ny_hi <= REM_W'(n_s2c[29:10]);
        r_s2_ny_lo <= {n_s2c[9:0], 16'b0};
        r_s2_nz_hi <= REM_W'(r_s1_dz2[30:4]);
        r_s2_nz_lo <= {r_s1_dz2[3:0], 22'b0};
        // P0
        r_p0_mode <= div_side.mode;
        r_p0_zd   <= div_side.zd;
        r_p0_ay   <= div_qy;
        r_p0_az   <= div_qz;
        r_p0_cy   <= fetch_coefs(1'b0, div_side.rt, div_side.mode);
        r_p0_cz   <= fetch_coefs(1'b1, div_side.rt, div_side.mode);
    end

    cep_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s2_v),
        .i_side     (r_s2_side),
        .i_den      (r_s2_den),
        .i_num_y_hi (r_s2_ny_hi),
        .i_num_y_lo (r_s2_ny_lo),
        .i_num_z_hi (r_s2_nz_hi),
        .i_num_z_lo (r_s2_nz_lo),
        .o_valid    (div_v),
        .o_side     (div_side),
        .o_quot_y   (div_qy),
        .o_quot_z   (div_qz)
    );

    cep_poly u_poly_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p0_v),
        .i_mode  (r_p0_mode),
        .i_coefs (r_p0_cy),
        .i_zd    (r_p0_zd),
        .i_a     (r_p0_ay),
        .i_gain  (r_corr_y),
        .o_valid (lane_y_v),
        .o_err   (o_err_y2)
    );

    cep_poly u_poly_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p0_v),
        .i_mode  (r_p0_mode),
        .i_coefs (r_p0_cz),
        .i_zd    (r_p0_zd),
        .i_a     (r_p0_az),
        .i_gain  (r_corr_z),
        .o_valid (lane_z_v),
        .o_err   (o_err_z2)
    );

    assign o_valid = lane_y_v;

    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("accepted transaction produced no result");

    a_result_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result without accepted transaction");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_y_v == lane_z_v)
        else $error("y and z lanes out of step");

endmodule
`default_nettype wire
